// ----- src/timestamp_field_parser_core_macros.svh -----
// assertion macros for the timestamp field parser
// used by the rtl files that carry concurrent assertions, needs nothing else
`ifndef TIMESTAMP_FIELD_PARSER_CORE_MACROS_SVH
`define TIMESTAMP_FIELD_PARSER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define TFP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tfp assertion failed");

// next-cycle implication, disabled during reset
`define TFP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tfp assertion failed");

`endif

// ----- src/tfp_pkg.sv -----
// shared types, constants and codes of the timestamp field parser
// used by the interfaces and by every module, depends on nothing
package tfp_pkg;

   localparam int FIELD_BUFFER_BYTES = 32;
   localparam int KEPT_W = $clog2(FIELD_BUFFER_BYTES);
   localparam logic [KEPT_W-1:0] KEPT_LIMIT = KEPT_W'(FIELD_BUFFER_BYTES - 1);

   localparam int CHAR_W = 8;
   localparam int VALUE_W = 31;
   localparam logic [VALUE_W-1:0] VALUE_MAX = '1;
   localparam int FIELD_COUNT = 6;
   localparam int SLOT_W = 3;
   localparam int INDEX_W = 2;

   localparam logic [SLOT_W-1:0] SLOT_MONTH = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_DAY = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_HOUR = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_MINUTE = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_SECOND = 3'd4;
   localparam logic [SLOT_W-1:0] SLOT_MILLIS = 3'd5;

   localparam logic KIND_DATE = 1'b0;
   localparam logic KIND_TIME = 1'b1;

   localparam logic [INDEX_W-1:0] LAST_DATE_INDEX = 2'd1;
   localparam logic [INDEX_W-1:0] LAST_TIME_INDEX = 2'd3;
   localparam logic [INDEX_W-1:0] FRAC_TIME_INDEX = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_FIRST_KEPT = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_LAST_KEPT = 8'd126;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PLUS = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
   localparam logic [CHAR_W-1:0] DELIM_DATE = 8'h2F;
   localparam logic [CHAR_W-1:0] DELIM_TIME = 8'h3A;
   localparam logic [CHAR_W-1:0] DELIM_FRAC = 8'h2E;
   localparam logic [CHAR_W-1:0] DELIM_END = 8'h00;

   typedef enum logic [3:0] {
      PH_BEFORE  = 4'b0001,
      PH_NUMBER  = 4'b0010,
      PH_STOPPED = 4'b0100,
      PH_CLOSED  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic last_char;
      logic cmd;
   } req_item_type;

   typedef struct packed {
      logic status;
      logic token_kind;
      logic [FIELD_COUNT-1:0][VALUE_W-1:0] fields;
   } rsp_item_type;

   typedef struct packed {
      logic kind;
      logic [INDEX_W-1:0] field_index;
      phase_type phase;
      logic negative;
      logic [VALUE_W-1:0] acc;
      logic [KEPT_W-1:0] kept;
      logic limit_pending;
      logic error;
   } parse_state_type;

   typedef struct packed {
      logic valid;
      logic [SLOT_W-1:0] slot;
      logic [VALUE_W-1:0] value;
   } store_type;

endpackage

// ----- src/tfp_stream_if.sv -----
// valid/ready channel interfaces for the parser's byte input and result output
// depends on tfp_pkg for field widths
interface tfp_req_if;
   logic valid;
   logic ready;
   logic [tfp_pkg::CHAR_W-1:0] char_code;
   logic last_char;
   logic cmd;

   modport source (output valid, output char_code, output last_char, output cmd,
                   input ready);
   modport sink (input valid, input char_code, input last_char, input cmd,
                 output ready);
endinterface

interface tfp_rsp_if;
   logic valid;
   logic ready;
   logic status;
   logic token_kind;
   logic [tfp_pkg::VALUE_W-1:0] month;
   logic [tfp_pkg::VALUE_W-1:0] day;
   logic [tfp_pkg::VALUE_W-1:0] hour;
   logic [tfp_pkg::VALUE_W-1:0] minute;
   logic [tfp_pkg::VALUE_W-1:0] second_val;
   logic [tfp_pkg::VALUE_W-1:0] millis;

   modport source (output valid, output status, output token_kind, output month,
                   output day, output hour, output minute, output second_val,
                   output millis, input ready);
   modport sink (input valid, input status, input token_kind, input month,
                 input day, input hour, input minute, input second_val,
                 input millis, output ready);
endinterface

// ----- src/tfp_in_stage.sv -----
// input register of the parser: holds one byte transaction for the parse stage
// depends on tfp_pkg and tfp_req_if
module tfp_in_stage (
   input  logic clock,
   input  logic reset,
   tfp_req_if.sink req_stream,
   input  logic take,
   output logic item_valid,
   output tfp_pkg::req_item_type item
);

   logic item_valid_ff, item_valid_in;
   tfp_pkg::req_item_type item_ff, item_in;
   logic accept;

   assign req_stream.ready = !item_valid_ff || take;
   assign accept = req_stream.valid && req_stream.ready;

   always_comb begin
      item_valid_in = item_valid_ff;
      item_in = item_ff;
      if (accept) begin
         item_valid_in = 1'b1;
         item_in.char_code = req_stream.char_code;
         item_in.last_char = req_stream.last_char;
         item_in.cmd = req_stream.cmd;
      end else if (take) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = item_valid_ff;
   assign item = item_ff;

endmodule

// ----- src/tfp_parse_core.sv -----
// per-byte field parser: running field state, stored fields and result build
// depends on tfp_pkg and the assertion macros header
`include "timestamp_field_parser_core_macros.svh"

module tfp_parse_core (
   input  logic clock,
   input  logic reset,
   input  logic item_valid,
   input  tfp_pkg::req_item_type item,
   input  logic out_free,
   output logic take,
   output logic result_load,
   output tfp_pkg::rsp_item_type result
);

   function automatic logic is_final(input logic kind,
                                     input logic [tfp_pkg::INDEX_W-1:0] idx);
      is_final = (kind == tfp_pkg::KIND_TIME) ? (idx == tfp_pkg::LAST_TIME_INDEX)
                                              : (idx >= tfp_pkg::LAST_DATE_INDEX);
   endfunction

   function automatic logic [tfp_pkg::CHAR_W-1:0] delim_of(
      input logic kind, input logic [tfp_pkg::INDEX_W-1:0] idx);
      if (is_final(kind, idx)) begin
         delim_of = tfp_pkg::DELIM_END;
      end else if (kind == tfp_pkg::KIND_DATE) begin
         delim_of = tfp_pkg::DELIM_DATE;
      end else if (idx < tfp_pkg::FRAC_TIME_INDEX) begin
         delim_of = tfp_pkg::DELIM_TIME;
      end else begin
         delim_of = tfp_pkg::DELIM_FRAC;
      end
   endfunction

   function automatic logic [tfp_pkg::SLOT_W-1:0] slot_of(
      input logic kind, input logic [tfp_pkg::INDEX_W-1:0] idx);
      slot_of = ((kind == tfp_pkg::KIND_TIME) ? tfp_pkg::SLOT_HOUR : tfp_pkg::SLOT_MONTH)
                + {1'b0, idx};
   endfunction

   function automatic tfp_pkg::parse_state_type clear_field(
      input tfp_pkg::parse_state_type s);
      clear_field = s;
      clear_field.phase = tfp_pkg::PH_BEFORE;
      clear_field.negative = 1'b0;
      clear_field.acc = '0;
      clear_field.kept = '0;
      clear_field.limit_pending = 1'b0;
   endfunction

   function automatic tfp_pkg::parse_state_type advance(
      input tfp_pkg::parse_state_type s);
      advance = clear_field(s);
      advance.field_index = s.field_index + 2'd1;
   endfunction

   tfp_pkg::parse_state_type state_ff, state_in;
   tfp_pkg::parse_state_type eff_state, pass_state, next_state;
   logic at_start_ff, at_start_in;
   logic [tfp_pkg::FIELD_COUNT-1:0][tfp_pkg::VALUE_W-1:0] stored_ff, stored_in, merged;
   tfp_pkg::store_type store_a, store_b;
   logic run_normal;
   logic [tfp_pkg::CHAR_W-1:0] c;
   logic [tfp_pkg::CHAR_W-1:0] digit_diff;
   logic [tfp_pkg::VALUE_W+3:0] wide_acc;
   logic final_a, final_b;
   logic [tfp_pkg::CHAR_W-1:0] delim_a, delim_b;
   logic closed_now, stop_now;

   assign c = item.char_code;
   assign take = item_valid && (!item.last_char || out_free);
   assign result_load = take && item.last_char;
   assign digit_diff = c - tfp_pkg::CHAR_ZERO;

   // token start and pending buffer limit
   always_comb begin
      eff_state = state_ff;
      if (at_start_ff) begin
         eff_state = clear_field(state_ff);
         eff_state.kind = item.cmd;
         eff_state.field_index = '0;
         eff_state.error = 1'b0;
      end
      final_a = is_final(eff_state.kind, eff_state.field_index);
      delim_a = delim_of(eff_state.kind, eff_state.field_index);
      pass_state = eff_state;
      store_a = '0;
      run_normal = 1'b0;
      if (!eff_state.error && eff_state.phase != tfp_pkg::PH_CLOSED) begin
         if (eff_state.limit_pending) begin
            if (c != delim_a) begin
               pass_state.error = 1'b1;
            end else if (eff_state.negative && eff_state.acc != '0) begin
               pass_state.error = 1'b1;
            end else begin
               store_a.valid = 1'b1;
               store_a.slot = slot_of(eff_state.kind, eff_state.field_index);
               store_a.value = eff_state.acc;
               if (final_a) begin
                  pass_state.phase = tfp_pkg::PH_CLOSED;
               end else begin
                  pass_state = advance(eff_state);
                  run_normal = 1'b1;
               end
            end
         end else begin
            run_normal = 1'b1;
         end
      end
   end

   // ordinary byte handling
   always_comb begin
      next_state = pass_state;
      store_b = '0;
      closed_now = 1'b0;
      stop_now = 1'b0;
      wide_acc = ({4'b0, pass_state.acc} << 3) + ({4'b0, pass_state.acc} << 1)
                 + {31'b0, digit_diff[3:0]};
      final_b = is_final(pass_state.kind, pass_state.field_index);
      delim_b = delim_of(pass_state.kind, pass_state.field_index);
      if (run_normal) begin
         if (!(c inside {[tfp_pkg::CHAR_FIRST_KEPT:tfp_pkg::CHAR_LAST_KEPT]})) begin
            // skipped byte
         end else if (!final_b && c == delim_b) begin
            closed_now = 1'b1;
            if (pass_state.negative && pass_state.acc != '0) begin
               next_state.error = 1'b1;
            end else begin
               store_b.valid = 1'b1;
               store_b.slot = slot_of(pass_state.kind, pass_state.field_index);
               store_b.value = pass_state.acc;
               next_state = advance(pass_state);
               if (item.last_char) begin
                  next_state.error = 1'b1;
               end
            end
         end else begin
            case (pass_state.phase)
               tfp_pkg::PH_BEFORE: begin
                  if (c == tfp_pkg::CHAR_SPACE) begin
                     next_state.phase = tfp_pkg::PH_BEFORE;
                  end else if (c == tfp_pkg::CHAR_PLUS || c == tfp_pkg::CHAR_MINUS) begin
                     next_state.negative = (c == tfp_pkg::CHAR_MINUS);
                     next_state.phase = tfp_pkg::PH_NUMBER;
                  end else if (c inside {[tfp_pkg::CHAR_ZERO:tfp_pkg::CHAR_NINE]}) begin
                     next_state.acc = {27'b0, digit_diff[3:0]};
                     next_state.phase = tfp_pkg::PH_NUMBER;
                  end else begin
                     next_state.phase = tfp_pkg::PH_STOPPED;
                  end
               end
               tfp_pkg::PH_NUMBER: begin
                  if (c inside {[tfp_pkg::CHAR_ZERO:tfp_pkg::CHAR_NINE]}) begin
                     next_state.acc = (wide_acc > {4'b0, tfp_pkg::VALUE_MAX})
                                      ? tfp_pkg::VALUE_MAX
                                      : wide_acc[tfp_pkg::VALUE_W-1:0];
                  end else begin
                     next_state.phase = tfp_pkg::PH_STOPPED;
                  end
               end
               default: begin
                  next_state.phase = pass_state.phase;
               end
            endcase
            next_state.kept = pass_state.kept + 1'b1;
            if (next_state.kept >= tfp_pkg::KEPT_LIMIT) begin
               if (item.last_char) begin
                  next_state.error = 1'b1;
                  stop_now = 1'b1;
               end else begin
                  next_state.limit_pending = 1'b1;
               end
            end
         end
         if (item.last_char && !closed_now && !stop_now) begin
            if (next_state.negative && next_state.acc != '0) begin
               next_state.error = 1'b1;
            end else begin
               store_b.valid = 1'b1;
               store_b.slot = slot_of(next_state.kind, next_state.field_index);
               store_b.value = next_state.acc;
               if (!final_b) begin
                  next_state.error = 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      for (int j = 0; j < tfp_pkg::FIELD_COUNT; j++) begin
         merged[j] = stored_ff[j];
         if (store_a.valid && store_a.slot == tfp_pkg::SLOT_W'(j)) begin
            merged[j] = store_a.value;
         end
         if (store_b.valid && store_b.slot == tfp_pkg::SLOT_W'(j)) begin
            merged[j] = store_b.value;
         end
      end
      stored_in = take ? merged : stored_ff;
      state_in = take ? next_state : state_ff;
      at_start_in = take ? item.last_char : at_start_ff;
      result.status = next_state.error;
      result.token_kind = next_state.kind;
      result.fields = merged;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.kind <= tfp_pkg::KIND_DATE;
         state_ff.field_index <= '0;
         state_ff.phase <= tfp_pkg::PH_BEFORE;
         state_ff.negative <= 1'b0;
         state_ff.acc <= '0;
         state_ff.kept <= '0;
         state_ff.limit_pending <= 1'b0;
         state_ff.error <= 1'b0;
         at_start_ff <= 1'b1;
         stored_ff <= '0;
      end else begin
         state_ff <= state_in;
         at_start_ff <= at_start_in;
         stored_ff <= stored_in;
      end
   end

   `TFP_ASSERT_IMPL(a_limit_at_full, clock, reset, state_ff.limit_pending, state_ff.kept == tfp_pkg::KEPT_LIMIT)
   `TFP_ASSERT_IMPL(a_closed_final, clock, reset, state_ff.phase == tfp_pkg::PH_CLOSED, is_final(state_ff.kind, state_ff.field_index))
   `TFP_ASSERT_IMPL(a_no_overwrite, clock, reset, item_valid && item.last_char && !out_free, !take)
   `TFP_ASSERT_NEXT(a_token_restart, clock, reset, take && item.last_char, at_start_ff)

endmodule

// ----- src/tfp_out_stage.sv -----
// result register of the parser: holds one result transaction until taken
// depends on tfp_pkg and tfp_rsp_if
module tfp_out_stage (
   input  logic clock,
   input  logic reset,
   input  logic load,
   input  tfp_pkg::rsp_item_type result,
   output logic out_free,
   tfp_rsp_if.source rsp_stream
);

   logic valid_ff, valid_in;
   tfp_pkg::rsp_item_type data_ff, data_in;

   assign out_free = !valid_ff || rsp_stream.ready;

   always_comb begin
      data_in = load ? result : data_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_stream.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_stream.valid = valid_ff;
   assign rsp_stream.status = data_ff.status;
   assign rsp_stream.token_kind = data_ff.token_kind;
   assign rsp_stream.month = data_ff.fields[tfp_pkg::SLOT_MONTH];
   assign rsp_stream.day = data_ff.fields[tfp_pkg::SLOT_DAY];
   assign rsp_stream.hour = data_ff.fields[tfp_pkg::SLOT_HOUR];
   assign rsp_stream.minute = data_ff.fields[tfp_pkg::SLOT_MINUTE];
   assign rsp_stream.second_val = data_ff.fields[tfp_pkg::SLOT_SECOND];
   assign rsp_stream.millis = data_ff.fields[tfp_pkg::SLOT_MILLIS];

endmodule

// ----- src/timestamp_field_parser_core.sv -----
// top level of the timestamp field parser: input register, parse stage, result register
// depends on tfp_pkg, tfp_stream_if, tfp_in_stage, tfp_parse_core, tfp_out_stage
//
// channel      dir  carries
// req_stream   in   char_code[7:0], last_char, cmd  (one token byte per transaction)
// rsp_stream   out  status, token_kind, month, day, hour, minute, second_val, millis
//
// one byte per cycle unless a last byte stalls; bytes are parsed from the input register
// a result is loaded into the result register when its last byte is parsed
// the field accumulator update (times ten, add, saturate) is a combinational path
// reset clears the field state and stored fields and starts a new token
// a waiting result stalls only a last byte; other bytes keep flowing
module timestamp_field_parser_core (
   input  logic clock,
   input  logic reset,
   tfp_req_if.sink req_stream,
   tfp_rsp_if.source rsp_stream
);

   logic item_valid;
   tfp_pkg::req_item_type item;
   logic take;
   logic result_load;
   tfp_pkg::rsp_item_type result;
   logic out_free;

   tfp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_stream),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   tfp_parse_core u_parse_core (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item        (item),
      .out_free    (out_free),
      .take        (take),
      .result_load (result_load),
      .result      (result)
   );

   tfp_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (result_load),
      .result     (result),
      .out_free   (out_free),
      .rsp_stream (rsp_stream)
   );

endmodule

// ----- sim/tfp_result_checker.sv -----
`timescale 1ns / 1ps
// result checker for timestamp_field_parser_core: watches both channels, predicts each
// token's result from the accepted bytes and compares it field by field
// depends on tfp_pkg and the channel interfaces in tfp_stream_if
module tfp_result_checker (
   input  logic clock,
   input  logic reset,
   tfp_req_if   req_mon,
   tfp_rsp_if   rsp_mon,
   output int   failures,
   output int   pending
);

   logic kind;
   logic [tfp_pkg::INDEX_W-1:0] field_idx;
   tfp_pkg::phase_type phase;
   logic neg;
   logic limit_pend;
   logic err;
   logic at_start;
   logic [tfp_pkg::VALUE_W-1:0] acc;
   int kept;
   logic [tfp_pkg::VALUE_W-1:0] stored [tfp_pkg::FIELD_COUNT];
   tfp_pkg::rsp_item_type due_results[$];

   function automatic void clear_field_state();
      phase = tfp_pkg::PH_BEFORE;
      neg = 1'b0;
      acc = '0;
      kept = 0;
      limit_pend = 1'b0;
   endfunction

   function automatic void reset_parser_model();
      kind = tfp_pkg::KIND_DATE;
      field_idx = '0;
      clear_field_state();
      err = 1'b0;
      at_start = 1'b1;
      foreach (stored[j]) stored[j] = '0;
   endfunction

   // negative values are rejected, -0 is stored as zero
   function automatic bit store_field_value();
      int slot;
      if (neg && acc != '0) begin
         err = 1'b1;
         return 1'b0;
      end
      slot = (kind == tfp_pkg::KIND_TIME) ? int'(tfp_pkg::SLOT_HOUR) + int'(field_idx)
                                          : int'(tfp_pkg::SLOT_MONTH) + int'(field_idx);
      if (slot < tfp_pkg::FIELD_COUNT) stored[slot] = acc;
      return 1'b1;
   endfunction

   function automatic void accumulate_char(input logic [tfp_pkg::CHAR_W-1:0] c);
      logic [tfp_pkg::VALUE_W+3:0] wide;
      if (phase == tfp_pkg::PH_BEFORE) begin
         if (c == tfp_pkg::CHAR_PLUS || c == tfp_pkg::CHAR_MINUS) begin
            neg = (c == tfp_pkg::CHAR_MINUS);
            phase = tfp_pkg::PH_NUMBER;
         end else if (c >= tfp_pkg::CHAR_ZERO && c <= tfp_pkg::CHAR_NINE) begin
            acc = c - tfp_pkg::CHAR_ZERO;
            phase = tfp_pkg::PH_NUMBER;
         end else if (c != tfp_pkg::CHAR_SPACE) begin
            phase = tfp_pkg::PH_STOPPED;
         end
      end else if (phase == tfp_pkg::PH_NUMBER) begin
         if (c >= tfp_pkg::CHAR_ZERO && c <= tfp_pkg::CHAR_NINE) begin
            wide = acc * (tfp_pkg::VALUE_W+4)'(10) + (c - tfp_pkg::CHAR_ZERO);
            acc = (wide > tfp_pkg::VALUE_MAX) ? tfp_pkg::VALUE_MAX
                                              : wide[tfp_pkg::VALUE_W-1:0];
         end else begin
            phase = tfp_pkg::PH_STOPPED;
         end
      end
   endfunction

   function automatic void apply_token_byte(input logic [tfp_pkg::CHAR_W-1:0] c,
                                            input logic last, input logic k);
      logic [tfp_pkg::INDEX_W-1:0] last_idx;
      logic [tfp_pkg::CHAR_W-1:0] delim;
      bit final_fld;
      bit busy;
      bit close_at_last;
      tfp_pkg::rsp_item_type res;
      if (at_start) begin
         kind = k;
         field_idx = '0;
         clear_field_state();
         err = 1'b0;
         at_start = 1'b0;
      end
      busy = 1'b1;
      // a delimiter that closes a full middle field is parsed again for the next one
      for (int round = 0; round < 3; round++) begin
         if (busy && !err && phase != tfp_pkg::PH_CLOSED) begin
            last_idx = (kind == tfp_pkg::KIND_TIME) ? tfp_pkg::LAST_TIME_INDEX
                                                    : tfp_pkg::LAST_DATE_INDEX;
            final_fld = (field_idx >= last_idx);
            if (final_fld) delim = tfp_pkg::DELIM_END;
            else if (kind == tfp_pkg::KIND_DATE) delim = tfp_pkg::DELIM_DATE;
            else delim = (field_idx < tfp_pkg::FRAC_TIME_INDEX) ? tfp_pkg::DELIM_TIME
                                                                : tfp_pkg::DELIM_FRAC;
            busy = 1'b0;
            if (limit_pend) begin
               if (c != delim) begin
                  err = 1'b1;
               end else if (store_field_value()) begin
                  if (final_fld) begin
                     phase = tfp_pkg::PH_CLOSED;
                  end else begin
                     field_idx++;
                     clear_field_state();
                     busy = 1'b1;
                  end
               end
            end else begin
               close_at_last = last;
               if (c >= tfp_pkg::CHAR_FIRST_KEPT && c <= tfp_pkg::CHAR_LAST_KEPT) begin
                  if (!final_fld && c == delim) begin
                     close_at_last = 1'b0;
                     if (store_field_value()) begin
                        field_idx++;
                        clear_field_state();
                        if (last) err = 1'b1;
                     end
                  end else begin
                     accumulate_char(c);
                     kept++;
                     if (kept + 1 >= tfp_pkg::FIELD_BUFFER_BYTES) begin
                        if (last) begin
                           err = 1'b1;
                           close_at_last = 1'b0;
                        end else begin
                           limit_pend = 1'b1;
                        end
                     end
                  end
               end
               if (close_at_last && store_field_value() && !final_fld) err = 1'b1;
            end
         end
      end
      if (last) begin
         at_start = 1'b1;
         res.status = err;
         res.token_kind = kind;
         for (int j = 0; j < tfp_pkg::FIELD_COUNT; j++) res.fields[j] = stored[j];
         due_results.push_back(res);
      end
   endfunction

   task automatic compare_field(input string label,
                                input logic [tfp_pkg::VALUE_W-1:0] want,
                                input logic [tfp_pkg::VALUE_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      tfp_pkg::rsp_item_type want;
      if (reset) begin
         reset_parser_model();
         due_results.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_results.size() == 0) begin
               $display("%0t: result transaction with none expected, actual status %0d",
                        $time, rsp_mon.status);
               failures++;
            end else begin
               want = due_results.pop_front();
               compare_field("status", want.status, rsp_mon.status);
               compare_field("token_kind", want.token_kind, rsp_mon.token_kind);
               compare_field("month", want.fields[tfp_pkg::SLOT_MONTH], rsp_mon.month);
               compare_field("day", want.fields[tfp_pkg::SLOT_DAY], rsp_mon.day);
               compare_field("hour", want.fields[tfp_pkg::SLOT_HOUR], rsp_mon.hour);
               compare_field("minute", want.fields[tfp_pkg::SLOT_MINUTE], rsp_mon.minute);
               compare_field("second_val", want.fields[tfp_pkg::SLOT_SECOND],
                             rsp_mon.second_val);
               compare_field("millis", want.fields[tfp_pkg::SLOT_MILLIS], rsp_mon.millis);
            end
         end
         if (req_mon.valid && req_mon.ready)
            apply_token_byte(req_mon.char_code, req_mon.last_char, req_mon.cmd);
      end
      pending = due_results.size();
   end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// top of the timestamp_field_parser_core testbench: clock, reset, byte stimulus,
// result-side flow control and the verdict; depends on tfp_pkg, tfp_stream_if and
// tfp_result_checker
module tb;

   localparam int HOLD_CYCLES = 300;
   localparam int RANDOM_BYTES = 1200;

   logic clock;
   logic reset;
   int failures;
   int pending;
   int send_idle_pct;
   int recv_idle_pct;
   int bytes_sent;
   bit hold_request;
   logic [tfp_pkg::CHAR_W-1:0] token_bytes[$];

   tfp_req_if req_stream();
   tfp_rsp_if rsp_stream();

   timestamp_field_parser_core uut (
      .clock(clock),
      .reset(reset),
      .req_stream(req_stream),
      .rsp_stream(rsp_stream)
   );

   tfp_result_checker checker_inst (
      .clock(clock),
      .reset(reset),
      .req_mon(req_stream),
      .rsp_mon(rsp_stream),
      .failures(failures),
      .pending(pending)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #1_000_000;
      $display("Verification failed");
      $finish;
   end

   // result side flow control, with one long hold-off on request
   initial begin
      rsp_stream.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stream.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stream.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_byte(input logic [tfp_pkg::CHAR_W-1:0] c, input logic last,
                            input logic k);
      if ($urandom_range(99) < send_idle_pct) begin
         req_stream.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_stream.valid <= 1'b1;
      req_stream.char_code <= c;
      req_stream.last_char <= last;
      req_stream.cmd <= k;
      @(posedge clock);
      while (!req_stream.ready) @(posedge clock);
      bytes_sent++;
   endtask

   // cmd only counts on the first byte, the rest get random values
   task automatic send_token(input logic kind);
      int n;
      n = token_bytes.size();
      for (int i = 0; i < n; i++)
         send_byte(token_bytes[i], i == n - 1, (i == 0) ? kind : 1'($urandom_range(1)));
   endtask

   task automatic send_text(input string s, input logic kind);
      token_bytes.delete();
      for (int i = 0; i < s.len(); i++) token_bytes.push_back(s[i]);
      send_token(kind);
   endtask

   function automatic logic [tfp_pkg::CHAR_W-1:0] delimiter_after(input logic kind,
                                                                  input int f);
      if (kind == tfp_pkg::KIND_DATE) return tfp_pkg::DELIM_DATE;
      return (f < int'(tfp_pkg::FRAC_TIME_INDEX)) ? tfp_pkg::DELIM_TIME
                                                  : tfp_pkg::DELIM_FRAC;
   endfunction

   function automatic logic [tfp_pkg::CHAR_W-1:0] skipped_char();
      if ($urandom_range(1)) return tfp_pkg::CHAR_W'($urandom_range(31));
      return tfp_pkg::CHAR_W'($urandom_range(127, 255));
   endfunction

   function automatic logic [tfp_pkg::CHAR_W-1:0] special_char();
      case ($urandom_range(6))
         0: return tfp_pkg::CHAR_SPACE;
         1: return tfp_pkg::CHAR_PLUS;
         2: return tfp_pkg::CHAR_MINUS;
         3: return tfp_pkg::DELIM_DATE;
         4: return tfp_pkg::DELIM_TIME;
         5: return tfp_pkg::DELIM_FRAC;
         default: return tfp_pkg::DELIM_END;
      endcase
   endfunction

   function automatic logic [tfp_pkg::CHAR_W-1:0] noise_char();
      int sel;
      sel = $urandom_range(9);
      if (sel < 3) return skipped_char();
      if (sel < 6) return tfp_pkg::CHAR_W'($urandom_range(32, 126));
      return special_char();
   endfunction

   function automatic void add_field();
      int n_digits;
      int sel;
      bit zeros;
      if ($urandom_range(99) < 15) token_bytes.push_back(tfp_pkg::CHAR_SPACE);
      sel = $urandom_range(99);
      zeros = 1'b0;
      if (sel < 10) begin
         token_bytes.push_back(tfp_pkg::CHAR_PLUS);
      end else if (sel < 20) begin
         token_bytes.push_back(tfp_pkg::CHAR_MINUS);
         zeros = $urandom_range(1);
      end
      n_digits = ($urandom_range(9) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 3);
      for (int i = 0; i < n_digits; i++) begin
         if ($urandom_range(19) == 0) token_bytes.push_back(skipped_char());
         token_bytes.push_back(zeros ? tfp_pkg::CHAR_ZERO
                               : tfp_pkg::CHAR_W'(tfp_pkg::CHAR_ZERO + $urandom_range(9)));
      end
      if ($urandom_range(14) == 0)
         token_bytes.push_back(tfp_pkg::CHAR_W'($urandom_range(65, 90)));
   endfunction

   // one field is filled to the buffer limit; only the last field may lack its delimiter
   function automatic void add_limit_token(input logic kind);
      int last_f;
      int target;
      int n_spaces;
      int sel;
      last_f = (kind == tfp_pkg::KIND_TIME) ? int'(tfp_pkg::LAST_TIME_INDEX)
                                            : int'(tfp_pkg::LAST_DATE_INDEX);
      target = $urandom_range(last_f);
      for (int f = 0; f <= last_f; f++) begin
         if (f == target) begin
            n_spaces = $urandom_range(31);
            for (int i = 0; i < tfp_pkg::FIELD_BUFFER_BYTES - 1; i++)
               token_bytes.push_back(i < n_spaces ? tfp_pkg::CHAR_SPACE
                  : tfp_pkg::CHAR_W'(tfp_pkg::CHAR_ZERO + $urandom_range(9)));
            sel = $urandom_range(9);
            if (sel >= 6 && sel < 8) begin
               token_bytes.push_back(noise_char());
            end else if (sel < 6 && f == last_f) begin
               token_bytes.push_back(tfp_pkg::DELIM_END);
               repeat ($urandom_range(2)) token_bytes.push_back(noise_char());
            end
         end else begin
            add_field();
         end
         if (f < last_f) token_bytes.push_back(delimiter_after(kind, f));
      end
   endfunction

   task automatic send_random_token();
      int form;
      int keep;
      int last_f;
      logic kind;
      token_bytes.delete();
      kind = $urandom_range(1);
      form = $urandom_range(99);
      if (form < 70) begin
         last_f = (kind == tfp_pkg::KIND_TIME) ? int'(tfp_pkg::LAST_TIME_INDEX)
                                               : int'(tfp_pkg::LAST_DATE_INDEX);
         for (int f = 0; f <= last_f; f++) begin
            add_field();
            if (f < last_f) token_bytes.push_back(delimiter_after(kind, f));
         end
         if ($urandom_range(9) == 0) begin
            keep = $urandom_range(1, token_bytes.size());
            while (token_bytes.size() > keep) void'(token_bytes.pop_back());
         end
         if ($urandom_range(9) == 0)
            token_bytes[$urandom_range(token_bytes.size() - 1)] = special_char();
      end else if (form < 82) begin
         add_limit_token(kind);
      end else begin
         repeat ($urandom_range(1, 8)) token_bytes.push_back(noise_char());
      end
      send_token(kind);
   endtask

   initial begin
      reset = 1'b1;
      hold_request = 1'b0;
      bytes_sent = 0;
      send_idle_pct = 25;
      recv_idle_pct = 73;
      req_stream.valid <= 1'b0;
      req_stream.char_code <= '0;
      req_stream.last_char <= 1'b0;
      req_stream.cmd <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_text("1:2:3.4", tfp_pkg::KIND_TIME);
      send_text("12/31", tfp_pkg::KIND_DATE);
      send_text("9/", tfp_pkg::KIND_DATE);
      send_text("-0/7", tfp_pkg::KIND_DATE);
      send_text("-5/", tfp_pkg::KIND_DATE);
      send_text("7", tfp_pkg::KIND_TIME);
      token_bytes.delete();
      token_bytes.push_back(8'hFF);
      token_bytes.push_back(tfp_pkg::DELIM_END);
      send_token(tfp_pkg::KIND_DATE);

      bytes_sent = 0;
      for (int p = 0; p < 3; p++) begin
         send_idle_pct = (p == 0) ? 25 : (p == 1) ? 73 : 0;
         recv_idle_pct = (p == 0) ? 73 : (p == 1) ? 25 : 0;
         if (p == 2) hold_request = 1'b1;
         while (bytes_sent < (RANDOM_BYTES / 3) * (p + 1)) send_random_token();
      end

      req_stream.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
